>>> hdl/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

  // Width of the chunk size and byte counters.
  localparam int SIZE_BITS = 32;

  // Characters that the size, data and trailer lines are parsed against.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_A = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  // Request kinds carried in the input beat's tuser.
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_START_PHASE     = 1'b0;
  localparam logic CFG_START_REMAINING = 1'b1;

  // One input beat.
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic       error;
  } res_t;

  // Restart values held in the configuration registers.
  typedef struct packed {
    logic [1:0]  start_phase;
    logic [31:0] start_remaining;
  } start_cfg_t;

endpackage

`default_nettype wire

>>> hdl/hcbd_core.sv
// Parser state and the one-byte step of the chunked body decoder.
`default_nettype none

module hcbd_core import hcbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire item_t      item,
  input  wire start_cfg_t start_cfg,
  output res_t            res
);

  // Phase codes; the first four match the start_phase register encoding.
  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_CRLF  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_DONE  = 3'd4,
    PH_ERR   = 3'd5
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] chunk_left_r, chunk_left_nxt;
  logic [SIZE_BITS-1:0] size_accum_r, size_accum_nxt;
  logic                 saw_cr_r, saw_cr_nxt;
  logic                 in_ext_r, in_ext_nxt;

  logic [7:0]           b;
  logic                 is_hex;
  logic [3:0]           hex_val;
  logic                 size_ovf;
  logic [SIZE_BITS-1:0] chunk_dec;
  logic                 line_done;

  assign b         = item.in_byte;
  assign chunk_dec = chunk_left_r - SIZE_BITS'(1);
  // Any nonzero top nibble means one more hex digit cannot fit.
  assign size_ovf  = (size_accum_r[SIZE_BITS-1 -: 4] != 4'd0);

  // Hex digit decode.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (b inside {[CH_0:CH_9]}) begin
      hex_val = 4'(b - CH_0);
    end else if (b inside {[CH_LA:CH_LF_A]}) begin
      hex_val = 4'(b - CH_LA + 8'd10);
    end else if (b inside {[CH_UA:CH_UF]}) begin
      hex_val = 4'(b - CH_UA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Next state and result for the byte or restart at the step input.
  always_comb begin
    phase_nxt      = phase_r;
    chunk_left_nxt = chunk_left_r;
    size_accum_nxt = size_accum_r;
    saw_cr_nxt     = saw_cr_r;
    in_ext_nxt     = in_ext_r;
    line_done      = 1'b0;
    res            = '0;

    if (item.req_type == REQ_RESTART) begin
      phase_nxt      = phase_t'({1'b0, start_cfg.start_phase});
      chunk_left_nxt = start_cfg.start_remaining[SIZE_BITS-1:0];
      size_accum_nxt = '0;
      saw_cr_nxt     = 1'b0;
      in_ext_nxt     = 1'b0;
    end else begin
      case (phase_r)
        PH_SIZE: begin
          // A pending CR closes the size line on LF; otherwise it is an error outside an extension.
          if (saw_cr_r) begin
            saw_cr_nxt = 1'b0;
            if (b == CH_LF) begin
              chunk_left_nxt = size_accum_r;
              phase_nxt      = (size_accum_r == '0) ? PH_TRAIL : PH_DATA;
              size_accum_nxt = '0;
              in_ext_nxt     = 1'b0;
              line_done      = 1'b1;
            end else if (!in_ext_r) begin
              phase_nxt = PH_ERR;
              line_done = 1'b1;
            end
          end
          if (!line_done) begin
            if (b == CH_CR) begin
              saw_cr_nxt = 1'b1;
            end else if (in_ext_r) begin
              // Extension bytes are skipped.
            end else if (b == CH_SEMI) begin
              in_ext_nxt = 1'b1;
            end else if (!is_hex || size_ovf) begin
              phase_nxt = PH_ERR;
            end else begin
              size_accum_nxt = {size_accum_r[SIZE_BITS-5:0], hex_val};
            end
          end
        end
        PH_DATA: begin
          if (chunk_left_r == '0) begin
            // Nothing owed: this byte is the first of the closing CRLF.
            saw_cr_nxt = (b == CH_CR);
            phase_nxt  = (b == CH_CR) ? PH_CRLF : PH_ERR;
          end else begin
            res.data_valid = 1'b1;
            res.data_byte  = b;
            chunk_left_nxt = chunk_dec;
            if (chunk_dec == '0) begin
              phase_nxt  = PH_CRLF;
              saw_cr_nxt = 1'b0;
            end
          end
        end
        PH_CRLF: begin
          if (!saw_cr_r) begin
            if (b == CH_CR) begin
              saw_cr_nxt = 1'b1;
            end else begin
              phase_nxt = PH_ERR;
            end
          end else begin
            saw_cr_nxt = 1'b0;
            phase_nxt  = (b == CH_LF) ? PH_SIZE : PH_ERR;
          end
        end
        PH_TRAIL: begin
          // in_ext marks that the current trailer line has content.
          if (saw_cr_r) begin
            saw_cr_nxt = 1'b0;
            if (b == CH_LF) begin
              if (!in_ext_r) begin
                phase_nxt = PH_DONE;
              end
              in_ext_nxt = 1'b0;
              line_done  = 1'b1;
            end else begin
              in_ext_nxt = 1'b1;
            end
          end
          if (!line_done) begin
            if (b == CH_CR) begin
              saw_cr_nxt = 1'b1;
            end else begin
              in_ext_nxt = 1'b1;
            end
          end
        end
        default: begin
          // Done and error hold until restart.
        end
      endcase
      res.done_res = (phase_nxt == PH_DONE);
      res.error    = (phase_nxt == PH_ERR);
    end
  end

  // Parser state registers, updated once per stepped beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      chunk_left_r <= '0;
      size_accum_r <= '0;
      saw_cr_r     <= 1'b0;
      in_ext_r     <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      chunk_left_r <= chunk_left_nxt;
      size_accum_r <= size_accum_nxt;
      saw_cr_r     <= saw_cr_nxt;
      in_ext_r     <= in_ext_nxt;
    end
  end

  // A payload byte is never reported together with done or error.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.data_valid |-> !res.done_res && !res.error)
    else $error("payload byte flagged done or error");

  // Done and error are exclusive.
  a_done_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(res.done_res && res.error))
    else $error("done and error at once");

  // A restart loads the configured phase.
  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.req_type == REQ_RESTART |=>
      phase_r == phase_t'({1'b0, $past(start_cfg.start_phase)}))
    else $error("restart did not load the start phase");

  // The error state is left only through a restart.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR && !(step_en && item.req_type == REQ_RESTART) |=>
      phase_r == PH_ERR)
    else $error("error state left without restart");

endmodule

`default_nettype wire

>>> hdl/http_chunked_body_decoder.sv
// Top level of the chunked body decoder: stream ports, config and pipeline.
// An accepted beat is held in the input register, then its result is registered in the output register.
// One byte per cycle while the output is taken; the parser state updates once per stepped beat.
// The output register decouples the sides, so input is taken while a result waits if the input register is empty.
// Reset (rst_n low, synchronous) clears the parser to the size line, the config to 0,
// and empties both pipeline stages.
`default_nettype none

module http_chunked_body_decoder import hcbd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tuser,   // [0] req_type
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] data_byte, [8] done_res, [9] error, zero pad
  output logic             out_tuser,  // [0] data_valid
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_data
);

  logic       s1_valid_r;
  item_t      s1_item_r;
  logic       out_valid_r;
  res_t       out_res_r;
  start_cfg_t cfg_r;
  res_t       step_res;
  logic       advance;
  logic       step_en;

  // Output register frees up when empty or taken this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_START_PHASE:     cfg_r.start_phase     <= cfg_data[1:0];
        CFG_START_REMAINING: cfg_r.start_remaining <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.req_type <= in_tuser;
      s1_item_r.in_byte  <= in_tdata;
    end
  end

  hcbd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (s1_item_r),
    .start_cfg (cfg_r),
    .res       (step_res)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.data_valid;
  assign out_tdata  = {6'd0, out_res_r.error, out_res_r.done_res, out_res_r.data_byte};

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the chunked body decoder: directed bodies, restarts, random streams.
`default_nettype none

module tb;
  import hcbd_pkg::*;

  // Parser phases tracked by the prediction.
  typedef enum logic [2:0] {
    S_SIZE_LINE, S_DATA, S_DATA_CRLF, S_TRAILER, S_DONE, S_ERROR
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tuser = 1'b0;    // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] data_byte, [8] done_res, [9] error, zero pad
  logic        out_tuser;          // [0] data_valid
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_addr = 1'b0;
  logic [31:0] cfg_data = 32'h0;

  http_chunked_body_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted decoder state and restart registers.
  parse_phase_t dec_phase = S_SIZE_LINE;
  logic [31:0]  bytes_owed = '0;
  logic [31:0]  size_acc = '0;
  logic         cr_seen = 1'b0;
  logic         line_busy = 1'b0;
  logic [1:0]   restart_phase = '0;
  logic [31:0]  restart_owed = '0;

  res_t  pending_results[$];
  item_t body_q[$];
  int    src_idle_pct = 0;
  int    sink_stall_pct = 0;
  int    n_fail = 0;
  int    n_beats_in = 0;
  int    n_beats_out = 0;
  int    n_restarts = 0;

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
    if (b >= CH_LA && b <= CH_LF_A) return int'(b - CH_LA) + 10;
    if (b >= CH_UA && b <= CH_UF) return int'(b - CH_UA) + 10;
    return -1;
  endfunction

  // Size line: hex digits, optional extension, CR LF. Errors land on the offending byte.
  function automatic void size_line_char(input logic [7:0] b);
    int d;
    if (cr_seen) begin
      cr_seen = 1'b0;
      if (b == CH_LF) begin
        bytes_owed = size_acc;
        dec_phase = (size_acc == 0) ? S_TRAILER : S_DATA;
        size_acc = '0;
        line_busy = 1'b0;
        return;
      end
      if (!line_busy) begin
        dec_phase = S_ERROR;
        return;
      end
    end
    if (b == CH_CR) begin
      cr_seen = 1'b1;
      return;
    end
    if (line_busy) return;
    if (b == CH_SEMI) begin
      line_busy = 1'b1;
      return;
    end
    d = hex_digit(b);
    if (d < 0) begin
      dec_phase = S_ERROR;
      return;
    end
    // The next digit must still fit in the size counter.
    if ({32'd0, size_acc} > (64'h0000_0000_FFFF_FFFF - d) / 16) begin
      dec_phase = S_ERROR;
      return;
    end
    size_acc = size_acc * 16 + d;
  endfunction

  function automatic void data_crlf_char(input logic [7:0] b);
    if (!cr_seen) begin
      if (b == CH_CR) cr_seen = 1'b1;
      else dec_phase = S_ERROR;
    end else begin
      cr_seen = 1'b0;
      dec_phase = (b == CH_LF) ? S_SIZE_LINE : S_ERROR;
    end
  endfunction

  // Trailer lines are skipped; an empty line ends the body.
  function automatic void trailer_char(input logic [7:0] b);
    if (cr_seen) begin
      cr_seen = 1'b0;
      if (b == CH_LF) begin
        if (!line_busy) dec_phase = S_DONE;
        line_busy = 1'b0;
        return;
      end
      line_busy = 1'b1;
    end
    if (b == CH_CR) cr_seen = 1'b1;
    else line_busy = 1'b1;
  endfunction

  function automatic res_t decode_beat(input item_t it);
    res_t r;
    r = '0;
    // A restart reloads from the registers; the remaining count already fits 32 bits.
    if (it.req_type == REQ_RESTART) begin
      dec_phase = parse_phase_t'({1'b0, restart_phase});
      bytes_owed = restart_owed;
      size_acc = '0;
      cr_seen = 1'b0;
      line_busy = 1'b0;
      return r;
    end
    case (dec_phase)
      S_SIZE_LINE: size_line_char(it.in_byte);
      S_DATA: begin
        if (bytes_owed == 0) begin
          dec_phase = S_DATA_CRLF;
          cr_seen = 1'b0;
          data_crlf_char(it.in_byte);
        end else begin
          r.data_valid = 1'b1;
          r.data_byte = it.in_byte;
          bytes_owed = bytes_owed - 1;
          if (bytes_owed == 0) begin
            dec_phase = S_DATA_CRLF;
            cr_seen = 1'b0;
          end
        end
      end
      S_DATA_CRLF: data_crlf_char(it.in_byte);
      S_TRAILER: trailer_char(it.in_byte);
      default: ;
    endcase
    r.done_res = (dec_phase == S_DONE);
    r.error = (dec_phase == S_ERROR);
    return r;
  endfunction

  // Sends one beat; tvalid stays high after acceptance until the next call or a pause.
  task automatic send_beat(input logic req, input logic [7:0] b);
    item_t it;
    it.req_type = req;
    it.in_byte = b;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(decode_beat(it));
    n_beats_in++;
    if (req == REQ_RESTART) n_restarts++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(REQ_BYTE, s[i]);
  endtask

  task automatic restart_decoder();
    send_beat(REQ_RESTART, 8'($urandom_range(255)));
  endtask

  // Holds the sender until every result is back, then lets the pipeline settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_START_PHASE) restart_phase = val[1:0];
    else restart_owed = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // Result side: compare each accepted beat with the oldest prediction, then pick tready.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      n_beats_out++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b", out_tdata, out_tuser);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_valid", 8'(want.data_valid), 8'(out_tuser));
        check_field("data_byte", want.data_byte, out_tdata[7:0]);
        check_field("done_res", 8'(want.done_res), 8'(out_tdata[8]));
        check_field("error", 8'(want.error), 8'(out_tdata[9]));
      end
    end
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Body generation for the random part.
  function automatic void put(input logic [7:0] b);
    item_t it;
    it.req_type = REQ_BYTE;
    it.in_byte = b;
    body_q.push_back(it);
  endfunction

  function automatic void put_crlf();
    put(CH_CR);
    put(CH_LF);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return CH_0 + n;
    return (upper ? CH_UA : CH_LA) + n - 8'd10;
  endfunction

  // Any byte but CR and LF, for extensions and trailer lines.
  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_CR || b == CH_LF) b = CH_SEMI;
    return b;
  endfunction

  // A CR not followed by LF is ordinary content inside extensions and trailers.
  function automatic void put_lone_cr();
    if ($urandom_range(5) == 0) begin
      put(CH_CR);
      put(line_byte());
    end
  endfunction

  function automatic void put_size_line(input logic [31:0] size, input bit blank);
    int top;
    if (!blank) begin
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) put(CH_0);
      top = 7;
      while (top > 0 && size[top*4 +: 4] == 4'd0) top--;
      for (int i = top; i >= 0; i--) put(hex_char(size[i*4 +: 4], 1'($urandom_range(1))));
    end
    if ($urandom_range(3) == 0) begin
      put(CH_SEMI);
      repeat ($urandom_range(0, 6)) put(line_byte());
      put_lone_cr();
    end
    put_crlf();
  endfunction

  // Trailer lines, the closing empty line, and a few bytes after the end.
  function automatic void put_trailers();
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 5)) put(line_byte());
      put_lone_cr();
      put_crlf();
    end
    put_crlf();
    repeat ($urandom_range(0, 2)) put(8'($urandom_range(255)));
  endfunction

  // One body: restart, then mostly a well-formed chunked stream, sometimes noise.
  function automatic void build_body();
    item_t it;
    int kind;
    int idx;
    logic [31:0] size;
    body_q.delete();
    it.req_type = REQ_RESTART;
    it.in_byte = 8'($urandom_range(255));
    body_q.push_back(it);
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(3, 15)) put(8'($urandom_range(255)));
      return;
    end
    if (kind < 14) begin
      // Long size lines: large counts or overflow.
      repeat ($urandom_range(8, 10))
        put(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      put_crlf();
      repeat ($urandom_range(0, 4)) put(8'($urandom_range(255)));
      return;
    end
    // The stream picks up where the restart registers leave the parser.
    case (parse_phase_t'({1'b0, restart_phase}))
      S_DATA: begin
        if (restart_owed > 16) begin
          repeat ($urandom_range(1, 12)) put(8'($urandom_range(255)));
          return;
        end
        repeat (restart_owed) put(8'($urandom_range(255)));
        put_crlf();
      end
      S_DATA_CRLF: put_crlf();
      S_TRAILER: begin
        put_trailers();
        return;
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 6);
      put_size_line(size, 1'b0);
      repeat (size) put(8'($urandom_range(255)));
      put_crlf();
    end
    put_size_line(32'd0, 1'($urandom_range(1)));
    put_trailers();
    // Break some bodies: a corrupted byte or a restart in mid-stream.
    if ($urandom_range(6) == 0) begin
      idx = $urandom_range(1, body_q.size() - 1);
      it = body_q[idx];
      if ($urandom_range(3) == 0) it.req_type = REQ_RESTART;
      else it.in_byte = 8'($urandom_range(255));
      body_q[idx] = it;
    end
  endfunction

  // Extension with a lone CR, one data byte, empty size line, trailer, end, ignored byte.
  task automatic test_complete_body();
    send_text("1;\015x\015\012");
    send_beat(REQ_BYTE, 8'hFF);
    send_text("\015\012\015\012t\015\015\012\015\012z");
  endtask

  // Bad hex digit (then held), overflow at the ninth digit, CR without LF.
  task automatic test_size_line_errors();
    restart_decoder();
    send_text("1g\015\012");
    restart_decoder();
    send_text("fA09eF3b0");
    restart_decoder();
    send_text("2\015x");
  endtask

  task automatic test_missing_crlf();
    restart_decoder();
    send_text("1\015\012a\015b");
  endtask

  // Restart from start phases 1 to 3 with the extreme remaining counts.
  task automatic test_restart_settings();
    wait_drained();
    write_reg(CFG_START_PHASE, 32'd1);
    write_reg(CFG_START_REMAINING, 32'hFFFF_FFFF);
    restart_decoder();
    send_beat(REQ_BYTE, 8'h00);
    send_beat(REQ_BYTE, 8'hFF);
    wait_drained();
    // Nothing owed: the first byte already belongs to the CR LF after the data.
    write_reg(CFG_START_REMAINING, 32'd0);
    restart_decoder();
    send_text("\015\0120\015\012\015\012");
    wait_drained();
    write_reg(CFG_START_PHASE, 32'd2);
    restart_decoder();
    send_text("x\015");
    wait_drained();
    write_reg(CFG_START_PHASE, 32'd3);
    restart_decoder();
    send_text("\015\012z");
  endtask

  // Random bodies under changing restart settings and idle patterns.
  task automatic test_random_bodies();
    int sent;
    for (int p = 0; p < 12; p++) begin
      wait_drained();
      src_idle_pct = (p < 4) ? 10 : (p < 8) ? 84 : 0;
      sink_stall_pct = (p < 4) ? 84 : (p < 8) ? 10 : 0;
      write_reg(CFG_START_PHASE, p % 4);
      write_reg(CFG_START_REMAINING,
                (p == 5) ? 32'hFFFF_FFFF : (p == 9) ? 32'd0 : $urandom_range(12));
      sent = 0;
      while (sent < 112) begin
        build_body();
        foreach (body_q[i]) send_beat(body_q[i].req_type, body_q[i].in_byte);
        sent += body_q.size();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_idle_pct = 10;
    sink_stall_pct = 84;
    test_complete_body();
    test_size_line_errors();
    test_missing_crlf();
    test_restart_settings();
    test_random_bodies();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d beats (%0d restarts) and checked %0d result beats.",
             n_beats_in, n_restarts, n_beats_out);
    $display("Start phases 0 to 3 and remaining counts from 0 to all ones were exercised.");
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Timeout guard, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> http_chunked_body_decoder.f
hdl/hcbd_pkg.sv
hdl/hcbd_core.sv
hdl/http_chunked_body_decoder.sv
tb/sv/tb.sv
